// ===== rtl/env_sensor_compensation_assert.svh =====
// assertion helpers, sampled on the rising clock edge, off while reset is high
`ifndef ENV_SENSOR_COMPENSATION_ASSERT_SVH
`define ENV_SENSOR_COMPENSATION_ASSERT_SVH

// condition must hold at every edge
`define ESC_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent must hold at the same edge as the antecedent
`define ESC_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== rtl/esc_pkg.sv =====
package esc_pkg;

   localparam int unsigned DIV_STAGES = 32;
   localparam int unsigned FR_STAGES  = 15;

   localparam logic [2:0] REG_TEMP    = 3'd0;
   localparam logic [2:0] REG_PRESS_A = 3'd1;
   localparam logic [2:0] REG_PRESS_B = 3'd2;
   localparam logic [2:0] REG_PRESS_C = 3'd3;
   localparam logic [2:0] REG_HUM     = 3'd4;

   localparam logic [31:0] K_64000   = 32'd64000;
   localparam logic [31:0] K_2POW20  = 32'd1048576;
   localparam logic [31:0] K_3125    = 32'd3125;
   localparam logic [31:0] K_76800   = 32'd76800;
   localparam logic [31:0] K_HUM_MAX = 32'd419430400;
   localparam logic [31:0] K_2POW21  = 32'd2097152;
   localparam logic [31:0] K_32768   = 32'd32768;
   localparam logic [31:0] K_16384   = 32'd16384;
   localparam logic [31:0] K_8192    = 32'd8192;
   localparam logic [31:0] K_128     = 32'd128;

   typedef struct packed {
      logic [19:0] raw_press;
      logic [19:0] raw_temp;
      logic [15:0] raw_hum;
   } req_type;

   typedef struct packed {
      logic signed [23:0] temp_centi;
      logic [31:0]        press_pa;
      logic               press_invalid;
      logic [16:0]        hum_q10;
   } rsp_type;

   // coefficients, all widened to 32 bits
   typedef struct packed {
      logic [31:0] t1, t2, t3;
      logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] h1, h2, h3, h4, h5, h6;
   } coef_type;

   // results that ride beside the divider
   typedef struct packed {
      logic        dbl;
      logic        invalid;
      logic [23:0] temp;
      logic [16:0] hum;
   } side_type;

   typedef struct packed {
      logic [31:0] num;
      logic [31:0] rem;
      logic [31:0] den;
      side_type    side;
   } dstg_type;

   function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
      logic signed [31:0] s;
      s = x;
      return s >>> n;
   endfunction

   function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      p = a * b;
      return p[31:0];
   endfunction

endpackage

// ===== rtl/esc_front.sv =====
module esc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  esc_pkg::req_type  in_word,
   input  esc_pkg::coef_type coef,
   output logic              out_valid,
   output esc_pkg::dstg_type out_word
);
   import esc_pkg::*;

   typedef struct packed {
      logic [19:0] adc_p;
      logic [19:0] adc_t;
      logic [15:0] adc_h;
      logic [31:0] x1, d, m1, dd, a, m2, tf, tm, pa, ha, temp;
      logic [31:0] pdd, pa5, pa2, hh5, hh6, hh3, b1, c1, hx, hy, hb;
      logic [31:0] b2, a1, xy, b3, a2, d1, dv, n0, d2m, n1, d2, hm, hd2, h1m;
      logic [16:0] hum;
   } fr_type;

   fr_type st_ff [FR_STAGES];
   fr_type st_in [FR_STAGES];
   logic   vld_ff [FR_STAGES];
   logic [31:0] hfin;

   always_comb begin
      st_in[0] = '0;
      st_in[0].adc_p = in_word.raw_press;
      st_in[0].adc_t = in_word.raw_temp;
      st_in[0].adc_h = in_word.raw_hum;
      st_in[0].x1 = ({12'd0, in_word.raw_temp} >> 3) - (coef.t1 << 1);
      st_in[0].d  = ({12'd0, in_word.raw_temp} >> 4) - coef.t1;
      for (int k = 1; k < FR_STAGES; k++) begin
         st_in[k] = st_ff[k-1];
      end
      // temperature
      st_in[1].m1 = mul32(st_ff[0].x1, coef.t2);
      st_in[1].dd = mul32(st_ff[0].d, st_ff[0].d);
      st_in[2].a  = asr(st_ff[1].m1, 5'd11);
      st_in[2].m2 = mul32(asr(st_ff[1].dd, 5'd12), coef.t3);
      st_in[3].tf = st_ff[2].a + asr(st_ff[2].m2, 5'd14);
      st_in[4].tm = (st_ff[3].tf << 2) + st_ff[3].tf + K_128;
      st_in[4].pa = asr(st_ff[3].tf, 5'd1) - K_64000;
      st_in[4].ha = st_ff[3].tf - K_76800;
      // first products of pressure and humidity
      st_in[5].temp = asr(st_ff[4].tm, 5'd8);
      st_in[5].pdd  = mul32(asr(st_ff[4].pa, 5'd2), asr(st_ff[4].pa, 5'd2));
      st_in[5].pa5  = mul32(st_ff[4].pa, coef.p5);
      st_in[5].pa2  = mul32(coef.p2, st_ff[4].pa);
      st_in[5].hh5  = mul32(coef.h5, st_ff[4].ha);
      st_in[5].hh6  = mul32(st_ff[4].ha, coef.h6);
      st_in[5].hh3  = mul32(st_ff[4].ha, coef.h3);
      st_in[6].b1 = mul32(asr(st_ff[5].pdd, 5'd11), coef.p6);
      st_in[6].c1 = mul32(coef.p3, asr(st_ff[5].pdd, 5'd13));
      st_in[6].hx = asr(st_ff[5].hh6, 5'd10);
      st_in[6].hy = asr(st_ff[5].hh3, 5'd11) + K_32768;
      st_in[6].hb = asr((({16'd0, st_ff[5].adc_h} << 14) - (coef.h4 << 20)
                         - st_ff[5].hh5) + K_16384, 5'd15);
      st_in[7].b2 = st_ff[6].b1 + (st_ff[6].pa5 << 1);
      st_in[7].a1 = asr(asr(st_ff[6].c1, 5'd3) + asr(st_ff[6].pa2, 5'd1), 5'd18);
      st_in[7].xy = mul32(st_ff[6].hx, st_ff[6].hy);
      st_in[8].b3 = asr(st_ff[7].b2, 5'd2) + (coef.p4 << 16);
      st_in[8].a2 = mul32(K_32768 + st_ff[7].a1, coef.p1);
      st_in[8].d1 = asr(st_ff[7].xy, 5'd10) + K_2POW21;
      st_in[9].dv  = asr(st_ff[8].a2, 5'd15);
      st_in[9].n0  = (K_2POW20 - {12'd0, st_ff[8].adc_p}) - asr(st_ff[8].b3, 5'd12);
      st_in[9].d2m = mul32(st_ff[8].d1, coef.h2);
      st_in[10].n1 = mul32(st_ff[9].n0, K_3125);
      st_in[10].d2 = asr(st_ff[9].d2m + K_8192, 5'd14);
      // humidity tail
      st_in[11].hm  = mul32(st_ff[10].hb, st_ff[10].d2);
      st_in[12].hd2 = mul32(asr(st_ff[11].hm, 5'd15), asr(st_ff[11].hm, 5'd15));
      st_in[13].h1m = mul32(asr(st_ff[12].hd2, 5'd7), coef.h1);
      hfin = st_ff[13].hm - asr(st_ff[13].h1m, 5'd4);
      if (hfin[31]) begin
         hfin = '0;
      end
      if (hfin > K_HUM_MAX) begin
         hfin = K_HUM_MAX;
      end
      st_in[14].hum = hfin[28:12];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < FR_STAGES; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k < FR_STAGES; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // divider setup: shift before dividing unless the top bit is set
   always_comb begin
      out_word.num          = st_ff[FR_STAGES-1].n1[31] ? st_ff[FR_STAGES-1].n1
                                                         : (st_ff[FR_STAGES-1].n1 << 1);
      out_word.rem          = '0;
      out_word.den          = st_ff[FR_STAGES-1].dv;
      out_word.side.dbl     = st_ff[FR_STAGES-1].n1[31];
      out_word.side.invalid = (st_ff[FR_STAGES-1].dv == '0);
      out_word.side.temp    = st_ff[FR_STAGES-1].temp[23:0];
      out_word.side.hum     = st_ff[FR_STAGES-1].hum;
   end

   assign out_valid = vld_ff[FR_STAGES-1];

endmodule

// ===== rtl/esc_div.sv =====
`include "env_sensor_compensation_assert.svh"

module esc_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  esc_pkg::dstg_type in_word,
   output logic              out_valid,
   output esc_pkg::dstg_type out_word
);
   import esc_pkg::*;

   dstg_type dst_ff [DIV_STAGES];
   dstg_type dst_in [DIV_STAGES];
   logic     vld_ff [DIV_STAGES];

   // one quotient bit per stage, restoring
   function automatic dstg_type div_step(input dstg_type s);
      dstg_type r;
      logic [32:0] t;
      logic        ge;
      r  = s;
      t  = {s.rem, s.num[31]};
      ge = (t >= {1'b0, s.den});
      if (ge) begin
         t = t - {1'b0, s.den};
      end
      r.rem = t[31:0];
      r.num = {s.num[30:0], ge};
      return r;
   endfunction

   always_comb begin
      dst_in[0] = div_step(in_word);
      for (int k = 1; k < DIV_STAGES; k++) begin
         dst_in[k] = div_step(dst_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dst_ff <= dst_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k < DIV_STAGES; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   assign out_valid = vld_ff[DIV_STAGES-1];
   assign out_word  = dst_ff[DIV_STAGES-1];

   `ESC_IMPLY(a_rem_below_den, out_valid && (out_word.den != '0), out_word.rem < out_word.den, "remainder not below divisor")

endmodule

// ===== rtl/esc_back.sv =====
module esc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  esc_pkg::dstg_type in_word,
   input  esc_pkg::coef_type coef,
   output logic              out_valid,
   output esc_pkg::rsp_type  out_word
);
   import esc_pkg::*;

   logic [31:0] p_ff [2];
   logic [31:0] psq_ff, pb1_ff, pb2_ff, pm_ff;
   side_type    side_ff [2];
   logic [2:0]  vld_ff;
   logic [31:0] p_in, sum_in;
   rsp_type     out_ff;

   assign p_in   = in_word.side.dbl ? (in_word.num << 1) : in_word.num;
   assign sum_in = p_ff[1] + asr(asr(pm_ff, 5'd12) + asr(pb2_ff, 5'd13) + coef.p7, 5'd4);

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff[0]    <= p_in;
         psq_ff     <= mul32(p_in >> 3, p_in >> 3);
         pb1_ff     <= mul32(p_in >> 2, coef.p8);
         side_ff[0] <= in_word.side;
         p_ff[1]    <= p_ff[0];
         pm_ff      <= mul32(coef.p9, psq_ff >> 13);
         pb2_ff     <= pb1_ff;
         side_ff[1] <= side_ff[0];
         out_ff.temp_centi    <= side_ff[1].temp;
         out_ff.press_pa      <= side_ff[1].invalid ? '0 : sum_in;
         out_ff.press_invalid <= side_ff[1].invalid;
         out_ff.hum_q10       <= side_ff[1].hum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   assign out_valid = vld_ff[2];
   assign out_word  = out_ff;

endmodule

// ===== rtl/env_sensor_compensation.sv =====
// environmental sensor compensation, 32-bit integer formulas
// req channel: one word per raw sample set (pressure, temperature, humidity),
//   taken at a clock edge with req_valid high and req_stall low
// rsp channel: one word per sample set, in order: temperature in 0.01 degC,
//   pressure in Pa with an invalid flag (divisor zero), humidity in q10 %rh
// csr channel: coefficient writes by index, always ready; write only while idle
// latency: 49 cycles from the accepting edge until rsp_valid rises
//   50 register stages, the first loaded at the accepting edge: 15 of multiply
//   and shift, 32 divider stages (one quotient bit each), 3 of pressure
//   correction ending in the output register
// throughput: one word per cycle, every stage including the divider is pipelined
// stall: while rsp_valid and rsp_stall are both high the whole pipeline holds
//   and req_stall is raised; nothing is lost or repeated
// reset: synchronous, clears all valid bits and the coefficient registers
`include "env_sensor_compensation_assert.svh"

module env_sensor_compensation (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  esc_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output esc_pkg::rsp_type rsp_word,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [63:0]      csr_data
);
   import esc_pkg::*;

   // coefficient registers
   logic [47:0] temp_ff, pa_ff, pb_ff, pc_ff;
   logic [63:0] hum_ff;
   coef_type    coef;

   // pipeline advance, shared by every stage
   logic     adv;
   logic     fr_valid, dv_valid;
   dstg_type fr_word, dv_word;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff <= '0;
         pa_ff   <= '0;
         pb_ff   <= '0;
         pc_ff   <= '0;
         hum_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_TEMP:    temp_ff <= csr_data[47:0];
            REG_PRESS_A: pa_ff   <= csr_data[47:0];
            REG_PRESS_B: pb_ff   <= csr_data[47:0];
            REG_PRESS_C: pc_ff   <= csr_data[47:0];
            REG_HUM:     hum_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // field unpack: unsigned fields zero extended, signed ones sign extended
   always_comb begin
      coef.t1 = {16'd0, temp_ff[15:0]};
      coef.t2 = {{16{temp_ff[31]}}, temp_ff[31:16]};
      coef.t3 = {{16{temp_ff[47]}}, temp_ff[47:32]};
      coef.p1 = {16'd0, pa_ff[15:0]};
      coef.p2 = {{16{pa_ff[31]}}, pa_ff[31:16]};
      coef.p3 = {{16{pa_ff[47]}}, pa_ff[47:32]};
      coef.p4 = {{16{pb_ff[15]}}, pb_ff[15:0]};
      coef.p5 = {{16{pb_ff[31]}}, pb_ff[31:16]};
      coef.p6 = {{16{pb_ff[47]}}, pb_ff[47:32]};
      coef.p7 = {{16{pc_ff[15]}}, pc_ff[15:0]};
      coef.p8 = {{16{pc_ff[31]}}, pc_ff[31:16]};
      coef.p9 = {{16{pc_ff[47]}}, pc_ff[47:32]};
      coef.h1 = {24'd0, hum_ff[7:0]};
      coef.h2 = {{16{hum_ff[23]}}, hum_ff[23:8]};
      coef.h3 = {24'd0, hum_ff[31:24]};
      coef.h4 = {{20{hum_ff[43]}}, hum_ff[43:32]};
      coef.h5 = {{20{hum_ff[55]}}, hum_ff[55:44]};
      coef.h6 = {{24{hum_ff[63]}}, hum_ff[63:56]};
   end

   // hold everything while a finished word waits at the output
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   esc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_word   (req_word),
      .coef      (coef),
      .out_valid (fr_valid),
      .out_word  (fr_word)
   );

   esc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fr_valid),
      .in_word   (fr_word),
      .out_valid (dv_valid),
      .out_word  (dv_word)
   );

   esc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (dv_valid),
      .in_word   (dv_word),
      .coef      (coef),
      .out_valid (rsp_valid),
      .out_word  (rsp_word)
   );

   `ESC_IMPLY(a_invalid_zero, rsp_valid && rsp_word.press_invalid, rsp_word.press_pa == '0, "invalid pressure not forced to zero")
   `ESC_IMPLY(a_hum_clamped, rsp_valid, rsp_word.hum_q10 <= 17'd102400, "humidity above clamp")

endmodule
